// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property on the block clock, off during reset
`define FCDP_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// overlapped implication on the block clock, off during reset
`define FCDP_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/fcdp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcdp_pkg
// Types, widths and constants shared by the dosing pump timer modules.
// ----------------------------------------------------------------------------
package fcdp_pkg;

	localparam int NUM_CH    = 4;
	localparam int CH_W      = 2;
	localparam int AMT_W     = 24;
	localparam int SPD_W     = 16;
	localparam int MS_W      = 32;
	localparam int MASK_W    = NUM_CH;
	localparam int STATES_W  = 2 * NUM_CH;
	localparam int K_W       = 13;
	localparam int PROD_W    = AMT_W + K_W;
	localparam int DVD_W     = PROD_W + 1;
	localparam int DVS_W     = SPD_W + 1;
	localparam int CNT_W     = $clog2(DVD_W + 1);

	// ms per minute over hundredths: 60 * 1000 / 10
	localparam logic [K_W-1:0]   K_CONV      = K_W'(6000);
	localparam logic [SPD_W-1:0] SPEED_RESET = SPD_W'(1200);

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_VOL  = 2'd1,
		OP_DUR  = 2'd2,
		OP_ALL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CS_IDLE = 2'd0,
		CS_WAIT = 2'd1,
		CS_RUN  = 2'd2
	} chst_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_BUSY    = 2'd2
	} status_t;

	typedef struct packed {
		logic capture;
		logic tick;
		logic load_dur;
		logic mul;
		logic div_start;
		logic load_conv;
		logic prep;
		logic launch;
		logic idx_inc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic vol_zero;
		logic idx_last;
		logic prep_ok;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/fcdp_cmd_if.sv =====
// ----------------------------------------------------------------------------
// fcdp_cmd_if
// Command channel: one item per accepted valid/ready handshake.
// ----------------------------------------------------------------------------
interface fcdp_cmd_if;

	logic                            valid;
	logic                            ready;
	logic [1:0]                      opcode;
	logic [fcdp_pkg::CH_W-1:0]       channel;
	logic [fcdp_pkg::AMT_W-1:0]      amount;
	logic [fcdp_pkg::AMT_W-1:0]      vol_first;
	logic [fcdp_pkg::AMT_W-1:0]      vol_second;
	logic [fcdp_pkg::AMT_W-1:0]      vol_third;
	logic [fcdp_pkg::AMT_W-1:0]      vol_fourth;

	modport source (
		output valid, opcode, channel, amount, vol_first, vol_second, vol_third, vol_fourth,
		input  ready
	);

	modport sink (
		input  valid, opcode, channel, amount, vol_first, vol_second, vol_third, vol_fourth,
		output ready
	);

endinterface

// ===== rtl/fcdp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fcdp_rsp_if
// Result channel: one item per accepted valid/ready handshake.
// ----------------------------------------------------------------------------
interface fcdp_rsp_if;

	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic [fcdp_pkg::MASK_W-1:0]       pump_on_mask;
	logic [fcdp_pkg::STATES_W-1:0]     channel_states;
	logic                              any_busy;

	modport source (
		output valid, status, pump_on_mask, channel_states, any_busy,
		input  ready
	);

	modport sink (
		input  valid, status, pump_on_mask, channel_states, any_busy,
		output ready
	);

endinterface

// ===== rtl/fcdp_div.sv =====
// ----------------------------------------------------------------------------
// fcdp_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcdp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fcdp_pkg::DVD_W-1:0]  dividend,
	input  logic [fcdp_pkg::DVS_W-1:0]  divisor,
	output logic [fcdp_pkg::DVD_W-1:0]  quot,
	output logic                        done
);

	logic                         busy_q;
	logic                         done_q;
	logic [fcdp_pkg::CNT_W-1:0]   cnt_q;
	logic [fcdp_pkg::DVS_W-1:0]   rem_q;
	logic [fcdp_pkg::DVD_W-1:0]   quo_q;
	logic [fcdp_pkg::DVS_W-1:0]   dvs_q;
	logic [fcdp_pkg::DVS_W:0]     trial;
	logic [fcdp_pkg::DVS_W:0]     diff;
	logic                         ge;

	assign trial = {rem_q, quo_q[fcdp_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= fcdp_pkg::CNT_W'(fcdp_pkg::DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[fcdp_pkg::DVS_W-1:0] : trial[fcdp_pkg::DVS_W-1:0];
			quo_q <= {quo_q[fcdp_pkg::DVD_W-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

	`FCDP_CHECK_IMP(a_div_done_after_busy, done_q, $past(busy_q), "divider done without a run")
	`FCDP_CHECK_IMP(a_div_no_restart, start, !busy_q, "divider restarted while busy")

endmodule

// ===== rtl/fcdp_dp.sv =====
// ----------------------------------------------------------------------------
// fcdp_dp
// Datapath: speed registers, command capture, volume conversion, channel
// countdowns and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcdp_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fcdp_pkg::cmd_t                 cmd,
	output fcdp_pkg::sts_t                 sts,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_idx,
	input  logic [fcdp_pkg::SPD_W-1:0]     cfg_data,
	input  logic [1:0]                     opcode,
	input  logic [fcdp_pkg::CH_W-1:0]      channel,
	input  logic [fcdp_pkg::AMT_W-1:0]     amount,
	input  logic [fcdp_pkg::AMT_W-1:0]     vol_first,
	input  logic [fcdp_pkg::AMT_W-1:0]     vol_second,
	input  logic [fcdp_pkg::AMT_W-1:0]     vol_third,
	input  logic [fcdp_pkg::AMT_W-1:0]     vol_fourth,
	input  logic                           rsp_ready,
	output logic                           rsp_valid,
	output logic [1:0]                     rsp_status,
	output logic [fcdp_pkg::MASK_W-1:0]    rsp_mask,
	output logic [fcdp_pkg::STATES_W-1:0]  rsp_states,
	output logic                           rsp_busy
);

	logic [fcdp_pkg::SPD_W-1:0]                     speed_q [fcdp_pkg::NUM_CH];
	fcdp_pkg::op_t                                  op_q;
	logic [fcdp_pkg::CH_W-1:0]                      ch_q;
	logic [fcdp_pkg::AMT_W-1:0]                     amt_q;
	logic [fcdp_pkg::AMT_W-1:0]                     vol_q [fcdp_pkg::NUM_CH];
	logic [fcdp_pkg::CH_W-1:0]                      idx_q;
	fcdp_pkg::status_t                              st_q;
	logic [fcdp_pkg::MS_W-1:0]                      ms_q;
	logic [fcdp_pkg::PROD_W-1:0]                    prod_s1;
	logic [fcdp_pkg::SPD_W-1:0]                     spd_s1;
	logic                                           vzero_s1;
	fcdp_pkg::chst_t                                state_q [fcdp_pkg::NUM_CH];
	logic [fcdp_pkg::NUM_CH-1:0][fcdp_pkg::MS_W-1:0] rem_q;
	logic [fcdp_pkg::NUM_CH-1:0][fcdp_pkg::MS_W-1:0] rem_dec;
	logic [fcdp_pkg::NUM_CH-1:0]                    drive_q;
	logic [fcdp_pkg::NUM_CH-1:0]                    run_v;
	logic                                           valid_q;
	logic [1:0]                                     out_status_q;
	logic [fcdp_pkg::MASK_W-1:0]                    out_mask_q;
	logic [fcdp_pkg::STATES_W-1:0]                  out_states_q;
	logic                                           out_busy_q;

	logic [fcdp_pkg::CH_W-1:0]   cur_ch;
	logic [fcdp_pkg::AMT_W-1:0]  cur_vol;
	logic [fcdp_pkg::DVD_W-1:0]  dividend;
	logic [fcdp_pkg::DVD_W-1:0]  quot;
	logic                        div_done;
	logic [fcdp_pkg::MS_W-1:0]   conv_ms;
	fcdp_pkg::status_t           prep_res;
	logic [fcdp_pkg::STATES_W-1:0] states_v;

	assign cur_ch  = (op_q == fcdp_pkg::OP_ALL) ? idx_q : ch_q;
	assign cur_vol = (op_q == fcdp_pkg::OP_ALL) ? vol_q[idx_q] : amt_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcdp_pkg::NUM_CH; i++) begin
				speed_q[i] <= fcdp_pkg::SPEED_RESET;
			end
		end else if (cfg_we) begin
			speed_q[cfg_idx] <= cfg_data;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= fcdp_pkg::op_t'(opcode);
			ch_q     <= channel;
			amt_q    <= amount;
			vol_q[0] <= vol_first;
			vol_q[1] <= vol_second;
			vol_q[2] <= vol_third;
			vol_q[3] <= vol_fourth;
		end
	end

	// volume conversion
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1  <= fcdp_pkg::PROD_W'(cur_vol) * fcdp_pkg::PROD_W'(fcdp_pkg::K_CONV);
			spd_s1   <= speed_q[cur_ch];
			vzero_s1 <= (cur_vol == '0);
		end
	end

	assign dividend = {prod_s1, 1'b0} + fcdp_pkg::DVD_W'(spd_s1);

	fcdp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  ({spd_s1, 1'b0}),
		.quot     (quot),
		.done     (div_done)
	);

	always_comb begin
		if (vzero_s1) begin
			conv_ms = '0;
		end else if (spd_s1 == '0 || quot[fcdp_pkg::DVD_W-1:fcdp_pkg::MS_W] != '0) begin
			conv_ms = '1;
		end else begin
			conv_ms = quot[fcdp_pkg::MS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_dur) begin
			ms_q <= fcdp_pkg::MS_W'(amt_q);
		end else if (cmd.load_conv) begin
			ms_q <= conv_ms;
		end
	end

	always_comb begin
		if (ms_q == '0) begin
			prep_res = fcdp_pkg::ST_INVALID;
		end else if (state_q[cur_ch] != fcdp_pkg::CS_IDLE) begin
			prep_res = fcdp_pkg::ST_BUSY;
		end else begin
			prep_res = fcdp_pkg::ST_OK;
		end
	end

	// sequencing state: scan index and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			st_q  <= fcdp_pkg::ST_OK;
		end else begin
			if (cmd.capture) begin
				idx_q <= '0;
				st_q  <= fcdp_pkg::ST_OK;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmd.prep) begin
					st_q <= prep_res;
				end
			end
		end
	end

	// channels
	always_comb begin
		for (int i = 0; i < fcdp_pkg::NUM_CH; i++) begin
			rem_dec[i] = (rem_q[i] == '0) ? '0 : rem_q[i] - 1'b1;
			run_v[i]   = (state_q[i] == fcdp_pkg::CS_RUN);
			states_v[2*i +: 2] = state_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcdp_pkg::NUM_CH; i++) begin
				state_q[i] <= fcdp_pkg::CS_IDLE;
				rem_q[i]   <= '0;
				drive_q[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < fcdp_pkg::NUM_CH; i++) begin
				if (cmd.tick && state_q[i] == fcdp_pkg::CS_RUN) begin
					rem_q[i] <= rem_dec[i];
					if (rem_dec[i] == '0) begin
						state_q[i] <= fcdp_pkg::CS_IDLE;
						drive_q[i] <= 1'b0;
					end
				end
				if (cmd.prep && prep_res == fcdp_pkg::ST_OK && cur_ch == fcdp_pkg::CH_W'(i)) begin
					rem_q[i]   <= ms_q;
					state_q[i] <= fcdp_pkg::CS_WAIT;
				end
				if (cmd.launch && state_q[i] == fcdp_pkg::CS_WAIT) begin
					state_q[i] <= fcdp_pkg::CS_RUN;
					drive_q[i] <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= st_q;
			out_mask_q   <= drive_q;
			out_states_q <= states_v;
			out_busy_q   <= (states_v != '0);
		end
	end

	always_comb begin
		sts.op       = op_q;
		sts.vol_zero = (cur_vol == '0);
		sts.idx_last = (idx_q == fcdp_pkg::CH_W'(fcdp_pkg::NUM_CH - 1));
		sts.prep_ok  = (prep_res == fcdp_pkg::ST_OK);
		sts.div_done = div_done;
		sts.out_free = !valid_q || rsp_ready;
	end

	assign rsp_valid  = valid_q;
	assign rsp_status = out_status_q;
	assign rsp_mask   = out_mask_q;
	assign rsp_states = out_states_q;
	assign rsp_busy   = out_busy_q;

	`FCDP_CHECK(a_drive_matches_run, drive_q == run_v, "pump drive disagrees with run state")

endmodule

// ===== rtl/fcdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcdp_ctrl
// Controller: sequences decode, conversion, prepare, launch and result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcdp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  fcdp_pkg::sts_t   sts,
	output fcdp_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MUL,
		S_DSTART,
		S_DWAIT,
		S_PREP,
		S_LAUNCH,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		cmd_ready = 1'b0;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				cmd_ready   = 1'b1;
				cmd.capture = cmd_valid;
				if (cmd_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					fcdp_pkg::OP_TICK: begin
						cmd.tick = 1'b1;
						state_d  = S_EMIT;
					end
					fcdp_pkg::OP_VOL: begin
						state_d = S_MUL;
					end
					fcdp_pkg::OP_DUR: begin
						cmd.load_dur = 1'b1;
						state_d      = S_PREP;
					end
					default: begin
						state_d = S_SCAN;
					end
				endcase
			end
			S_SCAN: begin
				if (!sts.vol_zero) begin
					state_d = S_MUL;
				end else if (sts.idx_last) begin
					state_d = S_LAUNCH;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					cmd.load_conv = 1'b1;
					state_d       = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (!sts.prep_ok) begin
					state_d = S_EMIT;
				end else if (sts.op != fcdp_pkg::OP_ALL || sts.idx_last) begin
					state_d = S_LAUNCH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_LAUNCH: begin
				cmd.launch = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`FCDP_CHECK_IMP(a_accept_to_decode, cmd_valid && cmd_ready, ##1 state_q == S_DECODE, "accepted item not decoded")

endmodule

// ===== rtl/four_channel_dosing_pump_timer.sv =====
// ----------------------------------------------------------------------------
// four_channel_dosing_pump_timer
// Four pump channels with millisecond countdowns, started by volume or by
// duration, advanced by tick items.
//
//   port     dir    kind            fields
//   cmd      in     valid/ready     opcode channel amount vol_first..vol_fourth
//   rsp      out    valid/ready     status pump_on_mask channel_states any_busy
//   cfg_*    in     write only      cfg_we cfg_idx cfg_data (speed_ch0..3)
//
// Start by volume runs through the bit-serial divider. Start all runs one
// division per nonzero volume, done in order. One item is worked at a
// time; the next is taken once its result is loaded into the output
// register. A stalled result holds the controller before loading. Reset
// is asynchronous; speeds come up at 1200, channels idle.
// ----------------------------------------------------------------------------
module four_channel_dosing_pump_timer (
	input  logic                        clk,
	input  logic                        arst_n,
	fcdp_cmd_if.sink                    cmd,
	fcdp_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_idx,
	input  logic [fcdp_pkg::SPD_W-1:0]  cfg_data
);

	fcdp_pkg::cmd_t ctl_cmd;
	fcdp_pkg::sts_t dp_sts;

	fcdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.sts       (dp_sts),
		.cmd       (ctl_cmd)
	);

	fcdp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl_cmd),
		.sts        (dp_sts),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.opcode     (cmd.opcode),
		.channel    (cmd.channel),
		.amount     (cmd.amount),
		.vol_first  (cmd.vol_first),
		.vol_second (cmd.vol_second),
		.vol_third  (cmd.vol_third),
		.vol_fourth (cmd.vol_fourth),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_mask   (rsp.pump_on_mask),
		.rsp_states (rsp.channel_states),
		.rsp_busy   (rsp.any_busy)
	);

endmodule

// ===== tb/four_channel_dosing_pump_timer_tb.sv =====
// ----------------------------------------------------------------------------
// four_channel_dosing_pump_timer_tb
// Self-checking bench for the four channel dosing pump timer. Sends tick,
// start by volume, start by duration and start all items, predicts status,
// pump mask and channel states for each accepted item, and checks every
// result in order, with both channels stalling at random in most phases.
// ----------------------------------------------------------------------------
module four_channel_dosing_pump_timer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcdp_pkg::*;

	localparam int CYCLE_LIMIT   = 1500000;
	localparam int TAIL_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [1:0]       REG_SPEED_CH0 = 2'd0;
	localparam logic [AMT_W-1:0] AMT_MAX       = '1;
	localparam logic [MS_W-1:0]  MS_SAT        = '1;

	typedef struct {
		op_t                          op;
		logic [CH_W-1:0]              ch;
		logic [AMT_W-1:0]             amount;
		logic [NUM_CH-1:0][AMT_W-1:0] vol;
	} dose_cmd_t;

	typedef struct {
		status_t             status;
		logic [MASK_W-1:0]   mask;
		logic [STATES_W-1:0] states;
		logic                busy;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [SPD_W-1:0] cfg_data;

	fcdp_cmd_if cmd_bus ();
	fcdp_rsp_if rsp_bus ();

	four_channel_dosing_pump_timer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_bus),
		.rsp      (rsp_bus),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	logic [SPD_W-1:0] speed [NUM_CH];
	chst_t            ch_state [NUM_CH];
	logic [MS_W-1:0]  ch_left_ms [NUM_CH];
	logic             ch_pump [NUM_CH];

	outcome_t outcome_q [$];
	int       err_count = 0;
	int       src_idle = 0;
	int       rcv_idle = 0;
	int       cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("four_channel_dosing_pump_timer_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [MS_W-1:0] volume_to_ms(logic [AMT_W-1:0] vol,
			logic [SPD_W-1:0] spd);
		logic [63:0] num;
		logic [63:0] q;
		if (vol == '0)
			return '0;
		if (spd == '0)
			return MS_SAT;
		num = 64'(vol) * 64'(K_CONV);
		q = (64'd2 * num + 64'(spd)) / (64'd2 * 64'(spd));
		return (q > 64'(MS_SAT)) ? MS_SAT : q[MS_W-1:0];
	endfunction

	function automatic status_t claim_channel(int ch, logic [MS_W-1:0] ms);
		if (ms == '0)
			return ST_INVALID;
		if (ch_state[ch] != CS_IDLE)
			return ST_BUSY;
		ch_left_ms[ch] = ms;
		ch_state[ch] = CS_WAIT;
		return ST_OK;
	endfunction

	function automatic outcome_t apply_cmd(dose_cmd_t c);
		outcome_t o;
		status_t  st;
		st = ST_OK;
		case (c.op)
			OP_TICK: begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (ch_state[i] == CS_RUN) begin
						if (ch_left_ms[i] != '0)
							ch_left_ms[i] = ch_left_ms[i] - 1'b1;
						if (ch_left_ms[i] == '0) begin
							ch_pump[i] = 1'b0;
							ch_state[i] = CS_IDLE;
						end
					end
				end
			end
			OP_VOL: st = claim_channel(c.ch, volume_to_ms(c.amount, speed[c.ch]));
			OP_DUR: st = claim_channel(c.ch, MS_W'(c.amount));
			default: begin
				// stop at the first failing channel
				for (int i = 0; i < NUM_CH; i++) begin
					if (st == ST_OK && c.vol[i] != '0)
						st = claim_channel(i, volume_to_ms(c.vol[i], speed[i]));
				end
			end
		endcase
		if (c.op != OP_TICK && st == ST_OK) begin
			for (int i = 0; i < NUM_CH; i++) begin
				if (ch_state[i] == CS_WAIT) begin
					ch_state[i] = CS_RUN;
					ch_pump[i] = 1'b1;
				end
			end
		end
		o.status = st;
		o.mask = '0;
		o.states = '0;
		o.busy = 1'b0;
		for (int i = 0; i < NUM_CH; i++) begin
			o.mask[i] = ch_pump[i];
			o.states[2*i +: 2] = ch_state[i];
			if (ch_state[i] != CS_IDLE)
				o.busy = 1'b1;
		end
		return o;
	endfunction

	function automatic bit channels_in(chst_t s);
		for (int i = 0; i < NUM_CH; i++) begin
			if (ch_state[i] == s)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic dose_cmd_t make_cmd(op_t op, logic [CH_W-1:0] ch,
			logic [AMT_W-1:0] amount);
		dose_cmd_t c;
		c.op = op;
		c.ch = ch;
		c.amount = amount;
		c.vol = '0;
		return c;
	endfunction

	function automatic dose_cmd_t make_all(logic [AMT_W-1:0] v0, v1, v2, v3);
		dose_cmd_t c;
		c = make_cmd(OP_ALL, '0, '0);
		c.vol = {v3, v2, v1, v0};
		return c;
	endfunction

	// keep durations short enough for ticks to drain the channel
	function automatic logic [AMT_W-1:0] small_volume(int ch);
		return AMT_W'($urandom_range(int'(speed[ch]) / 150 + 1, 0));
	endfunction

	function automatic dose_cmd_t random_cmd();
		dose_cmd_t c;
		int        pick;
		pick = $urandom_range(99);
		c.ch = CH_W'($urandom_range(3));
		c.amount = AMT_W'($urandom);
		for (int i = 0; i < NUM_CH; i++)
			c.vol[i] = AMT_W'($urandom);
		if (pick < 50) begin
			c.op = OP_TICK;
		end else if (pick < 70) begin
			c.op = OP_VOL;
			if (ch_state[c.ch] == CS_IDLE)
				c.amount = small_volume(c.ch);
		end else if (pick < 88) begin
			c.op = OP_DUR;
			if (ch_state[c.ch] == CS_IDLE)
				c.amount = AMT_W'($urandom_range(40));
		end else begin
			c.op = OP_ALL;
			for (int i = 0; i < NUM_CH; i++) begin
				if ($urandom_range(9) < 3)
					c.vol[i] = '0;
				else if (ch_state[i] == CS_IDLE)
					c.vol[i] = small_volume(i);
			end
		end
		return c;
	endfunction

	task automatic send_cmd(dose_cmd_t c);
		if ($urandom_range(99) < src_idle) begin
			cmd_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.opcode <= c.op;
		cmd_bus.channel <= c.ch;
		cmd_bus.amount <= c.amount;
		cmd_bus.vol_first <= c.vol[0];
		cmd_bus.vol_second <= c.vol[1];
		cmd_bus.vol_third <= c.vol[2];
		cmd_bus.vol_fourth <= c.vol[3];
		do @(posedge clk); while (!cmd_bus.ready);
		outcome_q.push_back(apply_cmd(c));
	endtask

	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_speeds(logic [SPD_W-1:0] s0, s1, s2, s3);
		logic [SPD_W-1:0] v [NUM_CH];
		v = '{s0, s1, s2, s3};
		for (int i = 0; i < NUM_CH; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= REG_SPEED_CH0 + 2'(i);
			cfg_data <= v[i];
			speed[i] = v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_duration_start();
		send_cmd(make_cmd(OP_TICK, 2'd0, '0));
		send_cmd(make_cmd(OP_DUR, 2'd3, '0));
		send_cmd(make_cmd(OP_DUR, 2'd3, 24'd2));
		send_cmd(make_cmd(OP_DUR, 2'd3, 24'd5));
		repeat (2) send_cmd(make_cmd(OP_TICK, 2'd0, '0));
	endtask

	task automatic test_volume_start();
		send_cmd(make_cmd(OP_VOL, 2'd1, 24'd1));
		// zero volume on a busy channel: invalid wins over busy
		send_cmd(make_cmd(OP_VOL, 2'd1, '0));
		send_cmd(make_cmd(OP_VOL, 2'd2, 24'd1));
		send_cmd(make_cmd(OP_VOL, 2'd1, 24'd3));
		repeat (5) send_cmd(make_cmd(OP_TICK, 2'd0, '0));
	endtask

	task automatic test_start_all();
		send_cmd(make_all('0, '0, '0, '0));
		send_cmd(make_all(24'd1, '0, 24'd1, 24'd1));
		// ch1 prepared, ch2 busy: ch1 holds in waiting
		send_cmd(make_all('0, 24'd1, 24'd1, '0));
		send_cmd(make_all('0, '0, '0, '0));
		repeat (5) send_cmd(make_cmd(OP_TICK, 2'd0, '0));
	endtask

	task automatic test_random(int n, int s_idle, int r_idle,
			logic [SPD_W-1:0] s0, s1, s2, s3);
		wait_idle();
		program_speeds(s0, s1, s2, s3);
		src_idle = s_idle;
		rcv_idle = r_idle;
		repeat (n) send_cmd(random_cmd());
	endtask

	task automatic test_extremes();
		if (channels_in(CS_WAIT))
			send_cmd(make_all('0, '0, '0, '0));
		while (channels_in(CS_RUN))
			send_cmd(make_cmd(OP_TICK, 2'd0, '0));
		wait_idle();
		program_speeds(16'd1, 16'd65535, 16'd0, 16'd1200);
		src_idle = 0;
		rcv_idle = 0;
		send_cmd(make_cmd(OP_VOL, 2'd1, 24'd3));
		send_cmd(make_cmd(OP_VOL, 2'd1, AMT_MAX));
		send_cmd(make_cmd(OP_DUR, 2'd3, AMT_MAX));
		send_cmd(make_cmd(OP_VOL, 2'd2, '0));
		send_cmd(make_all(AMT_MAX, '0, 24'd5, '0));
		send_cmd(make_cmd(OP_TICK, 2'd0, '0));
		send_cmd(make_cmd(OP_DUR, 2'd0, 24'd1));
	endtask

	initial begin
		outcome_t want;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
				if (outcome_q.size() == 0) begin
					$error("result with no item pending: status %0d mask %0h states %0h",
						rsp_bus.status, rsp_bus.pump_on_mask, rsp_bus.channel_states);
					err_count++;
				end else begin
					want = outcome_q.pop_front();
					if (rsp_bus.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
						err_count++;
					end
					if (rsp_bus.pump_on_mask !== want.mask) begin
						$error("pump_on_mask: expected %0h, got %0h", want.mask,
							rsp_bus.pump_on_mask);
						err_count++;
					end
					if (rsp_bus.channel_states !== want.states) begin
						$error("channel_states: expected %0h, got %0h", want.states,
							rsp_bus.channel_states);
						err_count++;
					end
					if (rsp_bus.any_busy !== want.busy) begin
						$error("any_busy: expected %0d, got %0d", want.busy, rsp_bus.any_busy);
						err_count++;
					end
				end
			end
			rsp_bus.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	initial begin
		cmd_bus.valid <= 1'b0;
		cmd_bus.opcode <= OP_TICK;
		cmd_bus.channel <= '0;
		cmd_bus.amount <= '0;
		cmd_bus.vol_first <= '0;
		cmd_bus.vol_second <= '0;
		cmd_bus.vol_third <= '0;
		cmd_bus.vol_fourth <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_SPEED_CH0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		for (int i = 0; i < NUM_CH; i++) begin
			speed[i] = SPEED_RESET;
			ch_state[i] = CS_IDLE;
			ch_left_ms[i] = '0;
			ch_pump[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		src_idle = 17;
		rcv_idle = 72;
		test_duration_start();
		test_volume_start();
		test_start_all();
		test_random(250, 17, 72, 16'd1200, 16'd1200, 16'd1200, 16'd1200);
		test_random(250, 72, 17, 16'd65535, 16'd150, 16'd4800, 16'd999);
		test_random(250, 0, 0, 16'd3000, 16'd65535, 16'd150, 16'd600);
		test_extremes();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && outcome_q.size() == 0)
			$display("four_channel_dosing_pump_timer_tb: done, clean");
		else
			$display("four_channel_dosing_pump_timer_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fcdp_pkg.sv
rtl/fcdp_cmd_if.sv
rtl/fcdp_rsp_if.sv
rtl/fcdp_div.sv
rtl/fcdp_dp.sv
rtl/fcdp_ctrl.sv
rtl/four_channel_dosing_pump_timer.sv
tb/four_channel_dosing_pump_timer_tb.sv
